@@ hw/rtl/blz_pkg.sv @@
// Shared types and constants for the backward LZ77 decompressor.
// Depends on nothing; the top level, blz_history_ram and blz_decode_ctrl import it.
package blz_pkg;

   // Default history depth; the top level hands it down as a parameter.
   localparam int HISTORY_DEPTH_DEF = 8192;

   // Widths and constants of the token format.
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 5;   // match length 3..18
   localparam int DIST_W    = 13;  // match distance 3..4098
   localparam int BITS_W    = 4;   // tokens left in a flag byte, 0..8
   localparam int MIN_MATCH = 3;
   localparam int FLAG_TOKENS = 8;

   // Where the parser stands in the token stream.
   typedef enum logic [1:0] {
      PH_FLAG,      // expect a flag byte
      PH_TOKEN,     // expect a literal or the high byte of a pair
      PH_PAIR_LO    // expect the low byte of a pair
   } phase_type;

   // Control sequencer states.
   typedef enum logic [1:0] {
      ST_TOKEN,     // take compressed bytes
      ST_COPY_RD,   // issue the history read of one match byte
      ST_COPY_WR    // write back the byte and hand it to the output
   } ctrl_state_type;

   // One result beat.
   typedef struct packed {
      logic [BYTE_W-1:0] plain_byte;
      logic              run_end;
      logic              stream_end;
   } rsp_beat_type;

   // Strobes and write data toward the history memory.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [BYTE_W-1:0] wr_data;
   } mem_ctl_type;

endpackage

@@ hw/rtl/blz_chan_if.sv @@
// Valid/ready channel interfaces of the decompressor: compressed bytes in,
// plain bytes out. Standalone; no package needed.
interface blz_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       final_byte;

   modport source (output valid, code_byte, final_byte, input ready);
   modport sink   (input valid, code_byte, final_byte, output ready);
endinterface

interface blz_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] plain_byte;
   logic       run_end;
   logic       stream_end;

   modport source (output valid, plain_byte, run_end, stream_end, input ready);
   modport sink   (input valid, plain_byte, run_end, stream_end, output ready);
endinterface

@@ hw/rtl/backward_lz77_decompressor_top.sv @@
// Backward LZ77 decompressor: one compressed byte per transfer, output bytes
// in ascending history address order. A literal is registered and on rsp in
// the cycle after its transfer. A match is copied byte by byte (read then
// write-back per byte on the single history port pair); rsp stalls pause it.
// Reset is synchronous, active high; it clears control state only, history
// contents stay undefined until written.
module backward_lz77_decompressor_top
   import blz_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   localparam int AW = $clog2(HISTORY_DEPTH)
) (
   input  logic      clock,
   input  logic      reset,
   blz_req_if.sink   req_if,
   blz_rsp_if.source rsp_if
);

   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   logic              out_free;
   logic              out_load;
   rsp_beat_type      out_beat;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_beat_type      rsp_beat_ff, rsp_beat_in;

   // Parser and match copy sequencer; owns the write pointer.
   blz_decode_ctrl #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .out_free(out_free),
      .out_load(out_load),
      .out_beat(out_beat),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decoded bytes land here; matches read back from it.
   blz_history_ram #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock  (clock),
      .mem_ctl(mem_ctl),
      .wr_addr(wr_addr),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Output register: free when empty or when its byte transfers now.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = out_beat;
      end else if (rsp_if.ready) begin
         // drop the byte once it has transferred
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds without reset; only valid qualifies it.
   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.plain_byte = rsp_beat_ff.plain_byte;
   assign rsp_if.run_end    = rsp_beat_ff.run_end;
   assign rsp_if.stream_end = rsp_beat_ff.stream_end;

endmodule

@@ hw/rtl/blz_history_ram.sv @@
// History memory: one write port, one read port, registered read data.
// Depends on blz_pkg for the control struct.
module blz_history_ram
   import blz_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   localparam int AW = $clog2(HISTORY_DEPTH)
) (
   input  logic              clock,
   input  mem_ctl_type       mem_ctl,
   input  logic [AW-1:0]     wr_addr,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] history_mem [HISTORY_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         history_mem[wr_addr] <= mem_ctl.wr_data;
      end
   end

   // Hold read data until the next read strobe.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= history_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/blz_decode_ctrl.sv @@
// Token parser and match copy sequencer of the decompressor.
// Depends on blz_pkg and blz_req_if; drives blz_history_ram.
module blz_decode_ctrl
   import blz_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   localparam int AW = $clog2(HISTORY_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   blz_req_if.sink           req,
   input  logic              out_free,
   output logic              out_load,
   output rsp_beat_type      out_beat,
   output mem_ctl_type       mem_ctl,
   output logic [AW-1:0]     wr_addr,
   output logic [AW-1:0]     rd_addr,
   input  logic [BYTE_W-1:0] rd_data
);

   ctrl_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] flag_ff, flag_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [BYTE_W-1:0] pair_high_ff, pair_high_in;
   logic              finished_ff, finished_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              last_ff, last_in;

   logic              accept;
   logic              take;
   logic [AW-1:0]     wp_next;
   logic [AW:0]       diff;
   logic [BITS_W-1:0] bits_dec;

   assign accept   = req.valid && req.ready;
   assign take     = accept && !finished_ff;
   assign wp_next  = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   assign bits_dec = (bits_ff != '0) ? bits_ff - BITS_W'(1) : bits_ff;
   assign diff     = {1'b0, wp_ff} - (AW+1)'(dist_ff);

   // Source of the next match byte, wrapped into the history.
   assign rd_addr = diff[AW] ? AW'(diff + (AW+1)'(HISTORY_DEPTH)) : AW'(diff);
   assign wr_addr = wp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_TOKEN: begin
            if (take && phase_ff == PH_PAIR_LO) begin
               state_in = ST_COPY_RD;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            if (out_free) begin
               state_in = (cnt_ff == LEN_W'(1)) ? ST_TOKEN : ST_COPY_RD;
            end
         end
         default: begin
            state_in = ST_TOKEN;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req.ready        = finished_ff || (state_ff == ST_TOKEN && out_free);
      out_load         = 1'b0;
      out_beat         = '{plain_byte: req.code_byte, run_end: 1'b1,
                           stream_end: req.final_byte};
      mem_ctl          = '{wr_en: 1'b0, rd_en: 1'b0, wr_data: req.code_byte};
      phase_in         = phase_ff;
      flag_in          = flag_ff;
      bits_in          = bits_ff;
      pair_high_in     = pair_high_ff;
      finished_in      = finished_ff;
      wp_in            = wp_ff;
      cnt_in           = cnt_ff;
      dist_in          = dist_ff;
      last_in          = last_ff;
      unique case (state_ff)
         ST_TOKEN: begin
            if (take) begin
               finished_in = req.final_byte;
               unique case (phase_ff)
                  PH_FLAG: begin
                     flag_in  = req.code_byte;
                     bits_in  = BITS_W'(FLAG_TOKENS);
                     phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (!flag_ff[BYTE_W-1]) begin
                        // literal: store and emit in the same cycle
                        mem_ctl.wr_en = 1'b1;
                        out_load      = 1'b1;
                        wp_in         = wp_next;
                        flag_in       = flag_ff << 1;
                        bits_in       = bits_dec;
                        phase_in      = (bits_dec != '0) ? PH_TOKEN : PH_FLAG;
                     end else begin
                        pair_high_in = req.code_byte;
                        phase_in     = PH_PAIR_LO;
                     end
                  end
                  PH_PAIR_LO: begin
                     cnt_in   = LEN_W'(pair_high_ff[BYTE_W-1:4]) + LEN_W'(MIN_MATCH);
                     dist_in  = DIST_W'({pair_high_ff[3:0], req.code_byte})
                              + DIST_W'(MIN_MATCH);
                     last_in  = req.final_byte;
                     flag_in  = flag_ff << 1;
                     bits_in  = bits_dec;
                     phase_in = (bits_dec != '0) ? PH_TOKEN : PH_FLAG;
                  end
                  default: begin
                     phase_in = PH_FLAG;
                  end
               endcase
            end
         end
         ST_COPY_RD: begin
            mem_ctl.rd_en = 1'b1;
         end
         ST_COPY_WR: begin
            mem_ctl.wr_data = rd_data;
            out_beat = '{plain_byte: rd_data, run_end: cnt_ff == LEN_W'(1),
                         stream_end: (cnt_ff == LEN_W'(1)) && last_ff};
            if (out_free) begin
               mem_ctl.wr_en = 1'b1;
               out_load      = 1'b1;
               wp_in         = wp_next;
               cnt_in        = cnt_ff - LEN_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TOKEN;
         phase_ff     <= PH_FLAG;
         flag_ff      <= '0;
         bits_ff      <= '0;
         pair_high_ff <= '0;
         finished_ff  <= 1'b0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         flag_ff      <= flag_in;
         bits_ff      <= bits_in;
         pair_high_ff <= pair_high_in;
         finished_ff  <= finished_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      last_ff <= last_in;
   end

endmodule

@@ hw/rtl/blz_checker.sv @@
// Port-level checks of the decompressor, bound to its top level.
// Depends only on the top level's ports.
module blz_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_plain_byte,
   input logic       rsp_run_end,
   input logic       rsp_stream_end
);

   // Output holds while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_plain_byte)
         && $stable(rsp_run_end) && $stable(rsp_stream_end))
      else $error("rsp dropped or changed while stalled");

   // The last byte of the stream also closes its run.
   a_end_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_end)
      else $error("stream_end without run_end");

   // Nothing follows the final byte of the stream.
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_stream_end |=> !rsp_valid)
      else $error("rsp after stream_end");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind backward_lz77_decompressor_top blz_checker u_blz_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_plain_byte(rsp_if.plain_byte),
   .rsp_run_end   (rsp_if.run_end),
   .rsp_stream_end(rsp_if.stream_end)
);
